// ----- rtl/set_assoc_writeback_cache_tags_macros.svh -----
// Assertion macros used by the checker file sawc_checker.sv.
`ifndef SET_ASSOC_WRITEBACK_CACHE_TAGS_MACROS_SVH
`define SET_ASSOC_WRITEBACK_CACHE_TAGS_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SAWC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SAWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sawc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawc_pkg
// Types and constants shared by the cache tag engine modules.
// ----------------------------------------------------------------------------
package sawc_pkg;

  localparam int ADDR_W = 32;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W  = 3;

  // Operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_HIT       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS      = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EVICT     = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_INVAL     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_INVAL_MISS = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS   = 2'd3;

  localparam logic POLICY_FIFO = 1'b1;

  // Configuration reset values
  localparam logic [CFG_W-1:0] RST_OFFSET = 4'd6;
  localparam logic [CFG_W-1:0] RST_SETS   = 4'd8;
  localparam logic [CFG_W-1:0] RST_WAYS   = 4'd8;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_CALC
  } state_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;    // latch item and read its set row
    logic commit;  // write row back, update counters, load result
  } ctrl_cmd_t;

endpackage

// ----- rtl/sawc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawc_req_if / sawc_rsp_if
// Valid/ready channels for access requests and their results.
// ----------------------------------------------------------------------------
interface sawc_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic [sawc_pkg::ADDR_W-1:0] address;

  modport source (output valid, operation, address, input ready);
  modport sink   (input valid, operation, address, output ready);
endinterface

interface sawc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sawc_pkg::STATUS_W-1:0] status;
  logic [sawc_pkg::ADDR_W-1:0]   victim_address;
  logic                          victim_dirty;
  logic [sawc_pkg::CNT_W-1:0]    read_count;
  logic [sawc_pkg::CNT_W-1:0]    read_miss_count;
  logic [sawc_pkg::CNT_W-1:0]    write_count;
  logic [sawc_pkg::CNT_W-1:0]    write_miss_count;
  logic [sawc_pkg::CNT_W-1:0]    writeback_count;

  modport source (output valid, status, victim_address, victim_dirty, read_count,
                  read_miss_count, write_count, write_miss_count, writeback_count,
                  input ready);
  modport sink   (input valid, status, victim_address, victim_dirty, read_count,
                  read_miss_count, write_count, write_miss_count, writeback_count,
                  output ready);
endinterface

// ----- rtl/sawc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawc_ctrl
// Sequencer: accept an item, then commit it once the result slot is free.
// ----------------------------------------------------------------------------
module sawc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output sawc_pkg::ctrl_cmd_t cmd
);

  sawc_pkg::state_t state, state_next;
  logic             rsp_valid_next;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sawc_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    req_ready      = 1'b0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    case (state)
      sawc_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = sawc_pkg::ST_CALC;
        end
      end
      sawc_pkg::ST_CALC: begin
        // hold until the previous result leaves
        if (!rsp_valid || rsp_ready) begin
          cmd.commit     = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = sawc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sawc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/sawc_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawc_dpath
// Set row memory, tag compare, victim choice, policy update and counters.
// ----------------------------------------------------------------------------
module sawc_dpath #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8,
  parameter int AGE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sawc_pkg::ctrl_cmd_t             cmd,
  input  logic                            write_enable,
  input  logic [sawc_pkg::CFG_IDX_W-1:0]  write_index,
  input  logic [sawc_pkg::CFG_W-1:0]      write_data,
  input  logic [1:0]                      operation,
  input  logic [sawc_pkg::ADDR_W-1:0]     address,
  output logic [sawc_pkg::STATUS_W-1:0]   status,
  output logic [sawc_pkg::ADDR_W-1:0]     victim_address,
  output logic                            victim_dirty,
  output logic [sawc_pkg::CNT_W-1:0]      read_count,
  output logic [sawc_pkg::CNT_W-1:0]      read_miss_count,
  output logic [sawc_pkg::CNT_W-1:0]      write_count,
  output logic [sawc_pkg::CNT_W-1:0]      write_miss_count,
  output logic [sawc_pkg::CNT_W-1:0]      writeback_count
);

  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int ROWS   = 1 << SB_MAX;
  localparam int IW     = (SB_MAX > 0) ? SB_MAX : 1;
  localparam int WW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AW     = sawc_pkg::ADDR_W;
  localparam int CW     = sawc_pkg::CNT_W;

  typedef logic [MAX_WAYS-1:0]               way_vec_t;
  typedef logic [MAX_WAYS-1:0][AGE_BITS-1:0] age_row_t;
  typedef logic [MAX_WAYS-1:0][AW-1:0]       addr_row_t;

  // Configuration registers
  logic       policy;
  logic [3:0] off_bits;
  logic [3:0] set_bits;
  logic [3:0] ways_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy   <= 1'b0;
      off_bits <= sawc_pkg::RST_OFFSET;
      set_bits <= sawc_pkg::RST_SETS;
      ways_cfg <= sawc_pkg::RST_WAYS;
    end else if (write_enable) begin
      case (write_index)
        sawc_pkg::CFG_POLICY: policy   <= write_data[0];
        sawc_pkg::CFG_OFFSET: off_bits <= write_data;
        sawc_pkg::CFG_SETS:   set_bits <= write_data;
        sawc_pkg::CFG_WAYS:   ways_cfg <= write_data;
        default: ;
      endcase
    end
  end

  // Effective geometry
  logic [4:0]    sb;
  logic [4:0]    ways_n;
  logic [5:0]    tag_sh;
  logic [AW-1:0] tag_mask;
  logic [AW-1:0] set_mask;
  logic [AW-1:0] shifted;
  logic [IW-1:0] rd_set;

  always_comb begin
    sb = ({1'b0, set_bits} > 5'(SB_MAX)) ? 5'(SB_MAX) : {1'b0, set_bits};
    if (ways_cfg == 4'd0) begin
      ways_n = 5'd1;
    end else if ({1'b0, ways_cfg} > 5'(MAX_WAYS)) begin
      ways_n = 5'(MAX_WAYS);
    end else begin
      ways_n = {1'b0, ways_cfg};
    end
    tag_sh   = {2'b00, off_bits} + {1'b0, sb};
    tag_mask = {AW{1'b1}} << tag_sh;
    set_mask = ~({AW{1'b1}} << sb);
    shifted  = address >> off_bits;
    rd_set   = IW'(shifted & set_mask);
  end

  // Set row memory and per-row valid flags
  way_vec_t            mem_valid [ROWS];
  way_vec_t            mem_dirty [ROWS];
  age_row_t            mem_age   [ROWS];
  addr_row_t           mem_addr  [ROWS];
  logic [WW-1:0]       mem_fptr  [ROWS];
  logic [ROWS-1:0]     row_ok;

  way_vec_t      rd_valid, rd_dirty;
  age_row_t      rd_age;
  addr_row_t     rd_addr;
  logic [WW-1:0] rd_fptr;
  logic          rd_ok;
  logic [1:0]    op_q;
  logic [AW-1:0] addr_q;
  logic [IW-1:0] set_q;

  way_vec_t      nw_valid, nw_dirty;
  age_row_t      nw_age;
  addr_row_t     nw_addr;
  logic [WW-1:0] nw_fptr;

  // Read the set row on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_valid <= mem_valid[rd_set];
      rd_dirty <= mem_dirty[rd_set];
      rd_age   <= mem_age[rd_set];
      rd_addr  <= mem_addr[rd_set];
      rd_fptr  <= mem_fptr[rd_set];
      rd_ok    <= row_ok[rd_set];
      op_q     <= operation;
      addr_q   <= address;
      set_q    <= rd_set;
    end
  end

  // Write the updated row back
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem_valid[set_q] <= nw_valid;
      mem_dirty[set_q] <= nw_dirty;
      mem_age[set_q]   <= nw_age;
      mem_addr[set_q]  <= nw_addr;
      mem_fptr[set_q]  <= nw_fptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
    end else if (cmd.commit) begin
      row_ok[set_q] <= 1'b1;
    end
  end

  // Lookup and update of the row
  way_vec_t                   v, d, inuse, hit_vec, match_new;
  age_row_t                   a;
  logic [WW-1:0]              fp;
  logic                       found, have_free, is_write, is_inval;
  logic [WW-1:0]              hit_way, free_way, lru_way, victim;
  logic [AGE_BITS-1:0]        best;
  logic [4:0]                 fp_inc;
  logic [sawc_pkg::STATUS_W-1:0] st;
  logic [AW-1:0]              vaddr;
  logic                       vdirty, evict;

  always_comb begin
    v  = rd_ok ? rd_valid : '0;
    d  = rd_ok ? rd_dirty : '0;
    a  = rd_ok ? rd_age : '0;
    fp = rd_ok ? rd_fptr : '0;
    is_inval = op_q[1];
    is_write = (op_q == sawc_pkg::OP_WRITE);

    // compare tags and find the first hit, first free and oldest way
    found     = 1'b0;
    have_free = 1'b0;
    hit_way   = '0;
    free_way  = '0;
    lru_way   = '0;
    best      = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      inuse[w]   = (5'(w) < ways_n);
      hit_vec[w] = inuse[w] && v[w] && (((rd_addr[w] ^ addr_q) & tag_mask) == '0);
      if (hit_vec[w] && !found) begin
        found   = 1'b1;
        hit_way = WW'(w);
      end
      if (inuse[w] && !v[w] && !have_free) begin
        have_free = 1'b1;
        free_way  = WW'(w);
      end
      if (inuse[w] && (a[w] > best)) begin
        best    = a[w];
        lru_way = WW'(w);
      end
    end

    // choose the victim and advance the FIFO pointer
    nw_fptr = fp;
    fp_inc  = '0;
    if (have_free) begin
      victim = free_way;
    end else if (policy == sawc_pkg::POLICY_FIFO) begin
      victim = (5'(fp) < ways_n) ? fp : '0;
      fp_inc = 5'(victim) + 5'd1;
    end else begin
      victim = lru_way;
    end

    nw_valid  = v;
    nw_dirty  = d;
    nw_age    = a;
    nw_addr   = rd_addr;
    vaddr     = '0;
    vdirty    = 1'b0;
    evict     = 1'b0;
    match_new = '0;
    if (is_inval) begin
      if (found) begin
        st                = sawc_pkg::STATUS_INVAL;
        vaddr             = rd_addr[hit_way];
        vdirty            = d[hit_way];
        nw_valid[hit_way] = 1'b0;
        nw_dirty[hit_way] = 1'b0;
        nw_age[hit_way]   = '0;
      end else begin
        st = sawc_pkg::STATUS_INVAL_MISS;
      end
    end else if (found) begin
      st        = sawc_pkg::STATUS_HIT;
      match_new = hit_vec;
      if (is_write) begin
        nw_dirty[hit_way] = 1'b1;
      end
    end else begin
      if (have_free) begin
        st = sawc_pkg::STATUS_MISS;
      end else begin
        st     = sawc_pkg::STATUS_EVICT;
        evict  = 1'b1;
        vaddr  = rd_addr[victim];
        vdirty = d[victim];
        if (policy == sawc_pkg::POLICY_FIFO) begin
          nw_fptr = (fp_inc >= ways_n) ? '0 : WW'(fp_inc);
        end
      end
      nw_addr[victim]   = addr_q;
      nw_valid[victim]  = 1'b1;
      nw_dirty[victim]  = is_write;
      match_new[victim] = 1'b1;
    end

    // outside FIFO mode and invalidations, age every valid way in use; reset the accessed one
    if (!is_inval && policy != sawc_pkg::POLICY_FIFO) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (inuse[w] && nw_valid[w]) begin
          if (match_new[w]) begin
            nw_age[w] = '0;
          end else if (a[w] != {AGE_BITS{1'b1}}) begin
            nw_age[w] = a[w] + 1'b1;
          end
        end
      end
    end
  end

  // Saturating event counters
  always_ff @(posedge clk) begin
    if (rst) begin
      read_count       <= '0;
      read_miss_count  <= '0;
      write_count      <= '0;
      write_miss_count <= '0;
      writeback_count  <= '0;
    end else if (cmd.commit && !is_inval) begin
      if (is_write) begin
        if (write_count != {CW{1'b1}}) write_count <= write_count + 1'b1;
        if (!found && write_miss_count != {CW{1'b1}}) begin
          write_miss_count <= write_miss_count + 1'b1;
        end
      end else begin
        if (read_count != {CW{1'b1}}) read_count <= read_count + 1'b1;
        if (!found && read_miss_count != {CW{1'b1}}) begin
          read_miss_count <= read_miss_count + 1'b1;
        end
      end
      if (evict && vdirty && writeback_count != {CW{1'b1}}) begin
        writeback_count <= writeback_count + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status         <= st;
      victim_address <= vaddr;
      victim_dirty   <= vdirty;
    end
  end

endmodule

// ----- rtl/set_assoc_writeback_cache_tags.sv -----
`timescale 1ns / 1ps
// A result is registered when its item commits, after the set row has been
// read; the commit waits while an earlier result has not yet been taken.
// Items are taken one at a time: a new item is accepted only after the last
// one commits; the set row is read on accept and written back at commit.
// Reset: per-set row flags clear at once, so no clearing pass is needed;
// counters clear and configuration returns to its defaults.
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_tags
// Tag and replacement engine of a set-associative write-back cache.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache_tags #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8,
  parameter int AGE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_enable,
  input  logic [sawc_pkg::CFG_IDX_W-1:0] write_index,
  input  logic [sawc_pkg::CFG_W-1:0]     write_data,
  sawc_req_if.sink                       req,
  sawc_rsp_if.source                     rsp
);

  sawc_pkg::ctrl_cmd_t cmd;

  // Sequencer
  sawc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Datapath
  sawc_dpath #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS),
    .AGE_BITS (AGE_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .write_enable     (write_enable),
    .write_index      (write_index),
    .write_data       (write_data),
    .operation        (req.operation),
    .address          (req.address),
    .status           (rsp.status),
    .victim_address   (rsp.victim_address),
    .victim_dirty     (rsp.victim_dirty),
    .read_count       (rsp.read_count),
    .read_miss_count  (rsp.read_miss_count),
    .write_count      (rsp.write_count),
    .write_miss_count (rsp.write_miss_count),
    .writeback_count  (rsp.writeback_count)
  );

endmodule

// ----- rtl/sawc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawc_checker
// Port-level checks of the cache tag engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "set_assoc_writeback_cache_tags_macros.svh"

module sawc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [sawc_pkg::STATUS_W-1:0] rsp_status,
  input logic                          rsp_victim_dirty,
  input logic [sawc_pkg::CNT_W-1:0]    rsp_read_count
);

  // one item at a time: no new item right after one is taken
  `SAWC_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "item accepted while busy")
  // a waiting result stays up
  `SAWC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
  // only evictions and invalidations report a dirty victim
  `SAWC_ASSERT_NOW(a_dirty_victim, rsp_valid && rsp_victim_dirty, (rsp_status == sawc_pkg::STATUS_EVICT) || (rsp_status == sawc_pkg::STATUS_INVAL), "dirty victim on wrong status")
  // the read counter never goes down outside reset
  `SAWC_ASSERT_NOW(a_read_mono, !$past(rst), rsp_read_count >= $past(rsp_read_count), "read count decreased")

endmodule

bind set_assoc_writeback_cache_tags sawc_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_victim_dirty (rsp.victim_dirty),
  .rsp_read_count   (rsp.read_count)
);
